>>> rtl/core/lrb_pkg.sv
// Shared types, constants and helper functions for the line-aware receive ring buffer.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package lrb_pkg;

  localparam int DEPTH     = 64;
  localparam int CHANNELS  = 2;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MEM_DEPTH = CHANNELS * DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam int REQ_W  = 2;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 7;
  localparam int LEN_W  = 7;
  localparam int LC_W   = 7;
  localparam int STAT_W = 2;

  localparam logic [BYTE_W-1:0] CR_CODE  = 8'h0D;
  localparam logic [BYTE_W-1:0] LF_CODE  = 8'h0A;
  localparam logic [BYTE_W-1:0] NUL_BYTE = 8'h00;
  localparam logic [CNT_W-1:0]  MAX_OUT  = 7'd64;
  localparam logic [LEN_W-1:0]  LINE_CAP = 7'd63;
  localparam logic [LC_W-1:0]   LCNT_MAX = 7'd127;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_COUNT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LINE  = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NONE    = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNTERM  = 2'd2;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd3;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_PUSH,
    CMD_REPLY,
    CMD_START,
    CMD_COUNT_STEP,
    CMD_LINE_STEP,
    CMD_TERM
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t             op;
    logic [STAT_W-1:0]   status;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic ch_bad;
    logic empty;
    logic lc_zero;
    logic cnt_zero;
    logic at_end;
    logic cnt_done;
    logic is_cr;
  } stat_t;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [CH_W-1:0] ch,
                                                 input logic [PTR_W-1:0] p);
    return ADDR_W'(ADDR_W'(ch) * ADDR_W'(DEPTH)) + ADDR_W'(p);
  endfunction

endpackage

>>> rtl/core/lrb_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on lrb_pkg for field widths.
interface lrb_req_if;
  logic                          valid;
  logic                          ready;
  logic [lrb_pkg::REQ_W-1:0]     req_type;
  logic                          channel;
  logic [lrb_pkg::BYTE_W-1:0]    rx_byte;
  logic [lrb_pkg::CNT_W-1:0]     read_count;

  modport source (output valid, req_type, channel, rx_byte, read_count, input ready);
  modport sink   (input valid, req_type, channel, rx_byte, read_count, output ready);
endinterface

interface lrb_res_if;
  logic                          valid;
  logic                          ready;
  logic [lrb_pkg::BYTE_W-1:0]    out_byte;
  logic                          last;
  logic [lrb_pkg::STAT_W-1:0]    status;
  logic [lrb_pkg::LEN_W-1:0]     length;

  modport source (output valid, out_byte, last, status, length, input ready);
  modport sink   (input valid, out_byte, last, status, length, output ready);
endinterface

>>> rtl/core/lrb_ctrl.sv
// Request sequencer: decodes accepted requests and walks reads byte by byte.
// Depends on lrb_pkg; drives commands into lrb_dp and reads its status.
module lrb_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  input  logic [lrb_pkg::REQ_W-1:0]  req_type,
  input  lrb_pkg::stat_t             st,
  output lrb_pkg::cmd_t              cmd,
  output logic                       req_ready
);

  typedef enum logic [1:0] {S_IDLE, S_COUNT, S_LINE, S_TERM} state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '{op: lrb_pkg::CMD_NONE, status: lrb_pkg::ST_OK};
    state_next = state;
    req_ready  = (state == S_IDLE) && st.slot_free;
    case (state)
      S_IDLE: begin
        if (req_valid && req_ready) begin
          case (req_type)
            lrb_pkg::REQ_PUSH: begin
              if (st.ch_bad) begin
                cmd = '{op: lrb_pkg::CMD_REPLY, status: lrb_pkg::ST_NONE};
              end else begin
                cmd.op = lrb_pkg::CMD_PUSH;
              end
            end
            lrb_pkg::REQ_COUNT: begin
              if (st.ch_bad || st.empty) begin
                cmd = '{op: lrb_pkg::CMD_REPLY, status: lrb_pkg::ST_NONE};
              end else if (st.cnt_zero) begin
                cmd = '{op: lrb_pkg::CMD_REPLY, status: lrb_pkg::ST_OK};
              end else begin
                cmd.op     = lrb_pkg::CMD_START;
                state_next = S_COUNT;
              end
            end
            lrb_pkg::REQ_LINE: begin
              if (st.ch_bad || st.empty || st.lc_zero) begin
                cmd = '{op: lrb_pkg::CMD_REPLY, status: lrb_pkg::ST_NONE};
              end else begin
                cmd.op     = lrb_pkg::CMD_START;
                state_next = S_LINE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_COUNT: begin
        if (st.slot_free) begin
          cmd.op = lrb_pkg::CMD_COUNT_STEP;
          if (st.at_end || st.cnt_done) begin
            state_next = S_IDLE;
          end
        end
      end
      S_LINE: begin
        if (st.slot_free) begin
          cmd.op = lrb_pkg::CMD_LINE_STEP;
          if (st.is_cr) begin
            state_next = S_IDLE;
          end else if (st.at_end) begin
            state_next = S_TERM;
          end
        end
      end
      S_TERM: begin
        if (st.slot_free) begin
          cmd = '{op: lrb_pkg::CMD_TERM, status: lrb_pkg::ST_UNTERM};
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/core/lrb_dp.sv
// Ring storage, per-channel pointers and line counts, read walker and result register.
// Depends on lrb_pkg; commanded by lrb_ctrl.
module lrb_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  lrb_pkg::cmd_t               cmd,
  output lrb_pkg::stat_t              st,
  input  logic                        channel,
  input  logic [lrb_pkg::BYTE_W-1:0]  rx_byte,
  input  logic [lrb_pkg::CNT_W-1:0]   read_count,
  input  logic                        res_ready,
  output logic                        res_valid,
  output logic [lrb_pkg::BYTE_W-1:0]  out_byte,
  output logic                        last,
  output logic [lrb_pkg::STAT_W-1:0]  status,
  output logic [lrb_pkg::LEN_W-1:0]   length
);

  localparam int PW = lrb_pkg::PTR_W;
  localparam int CW = lrb_pkg::CH_W;

  logic [PW-1:0]                  wp [lrb_pkg::CHANNELS];
  logic [PW-1:0]                  rp [lrb_pkg::CHANNELS];
  logic [lrb_pkg::LC_W-1:0]       lc [lrb_pkg::CHANNELS];
  logic [lrb_pkg::BYTE_W-1:0]     mem [lrb_pkg::MEM_DEPTH];
  logic [lrb_pkg::BYTE_W-1:0]     mem_q;

  logic [CW-1:0]                  cur_ch;
  logic [PW-1:0]                  ptr;
  logic [lrb_pkg::LEN_W-1:0]      k;
  logic [lrb_pkg::CNT_W-1:0]      cnt;

  logic [CW-1:0]                  ch_in;
  logic [PW-1:0]                  ptr_n;
  logic [lrb_pkg::LEN_W-1:0]      k_n;
  logic                           full;
  logic                           is_lf;
  logic                           rd_en;
  logic [lrb_pkg::ADDR_W-1:0]     rd_addr;
  logic                           res_load;

  assign ch_in = CW'(channel);
  assign ptr_n = lrb_pkg::advance(ptr);
  assign k_n   = k + lrb_pkg::LEN_W'(1);
  assign full  = (lrb_pkg::advance(wp[ch_in]) == rp[ch_in]);
  assign is_lf = (mem_q == lrb_pkg::LF_CODE);

  always_comb begin
    st.slot_free = !res_valid || res_ready;
    st.ch_bad    = (32'(channel) >= 32'(lrb_pkg::CHANNELS));
    st.empty     = (rp[ch_in] == wp[ch_in]);
    st.lc_zero   = (lc[ch_in] == '0);
    st.cnt_zero  = (read_count == '0);
    st.at_end    = (ptr_n == wp[cur_ch]);
    st.cnt_done  = (k_n == cnt);
    st.is_cr     = (mem_q == lrb_pkg::CR_CODE);
  end

  // Read port: first byte at the channel's read pointer, then one ahead per step
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = lrb_pkg::mem_addr(cur_ch, ptr_n);
    case (cmd.op)
      lrb_pkg::CMD_START: begin
        rd_en   = 1'b1;
        rd_addr = lrb_pkg::mem_addr(ch_in, rp[ch_in]);
      end
      lrb_pkg::CMD_COUNT_STEP,
      lrb_pkg::CMD_LINE_STEP: begin
        rd_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == lrb_pkg::CMD_PUSH && !full) begin
      mem[lrb_pkg::mem_addr(ch_in, wp[ch_in])] <= rx_byte;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Pointers and line counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < lrb_pkg::CHANNELS; c++) begin
        wp[c] <= '0;
        rp[c] <= '0;
        lc[c] <= '0;
      end
    end else begin
      case (cmd.op)
        lrb_pkg::CMD_PUSH: begin
          if (!full) begin
            wp[ch_in] <= lrb_pkg::advance(wp[ch_in]);
            if (rx_byte == lrb_pkg::CR_CODE && lc[ch_in] < lrb_pkg::LCNT_MAX) begin
              lc[ch_in] <= lc[ch_in] + lrb_pkg::LC_W'(1);
            end
          end
        end
        lrb_pkg::CMD_COUNT_STEP: begin
          if (st.is_cr && lc[cur_ch] != '0) begin
            lc[cur_ch] <= lc[cur_ch] - lrb_pkg::LC_W'(1);
          end
          if (st.at_end || st.cnt_done) begin
            rp[cur_ch] <= ptr_n;
          end
        end
        lrb_pkg::CMD_LINE_STEP: begin
          if (st.is_cr) begin
            rp[cur_ch] <= ptr_n;
            lc[cur_ch] <= lc[cur_ch] - lrb_pkg::LC_W'(1);
          end
        end
        lrb_pkg::CMD_TERM: begin
          rp[cur_ch] <= ptr;
          lc[cur_ch] <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Walker registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      lrb_pkg::CMD_START: begin
        cur_ch <= ch_in;
        ptr    <= rp[ch_in];
        k      <= '0;
        cnt    <= (read_count > lrb_pkg::MAX_OUT) ? lrb_pkg::MAX_OUT : read_count;
      end
      lrb_pkg::CMD_COUNT_STEP: begin
        ptr <= ptr_n;
        k   <= k_n;
      end
      lrb_pkg::CMD_LINE_STEP: begin
        ptr <= ptr_n;
        if (!st.is_cr && !is_lf && k < lrb_pkg::LINE_CAP) begin
          k <= k_n;
        end
      end
      default: begin
      end
    endcase
  end

  // Commands that place a transfer in the result register
  always_comb begin
    case (cmd.op)
      lrb_pkg::CMD_PUSH,
      lrb_pkg::CMD_REPLY,
      lrb_pkg::CMD_COUNT_STEP,
      lrb_pkg::CMD_TERM: begin
        res_load = 1'b1;
      end
      lrb_pkg::CMD_LINE_STEP: begin
        res_load = st.is_cr || (!is_lf && k < lrb_pkg::LINE_CAP);
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= res_load || (res_valid && !res_ready);
      case (cmd.op)
        lrb_pkg::CMD_PUSH: begin
          out_byte  <= lrb_pkg::NUL_BYTE;
          last      <= 1'b1;
          status    <= full ? lrb_pkg::ST_OVERFLOW : lrb_pkg::ST_OK;
          length    <= '0;
        end
        lrb_pkg::CMD_REPLY: begin
          out_byte  <= lrb_pkg::NUL_BYTE;
          last      <= 1'b1;
          status    <= cmd.status;
          length    <= '0;
        end
        lrb_pkg::CMD_COUNT_STEP: begin
          out_byte  <= mem_q;
          last      <= st.at_end || st.cnt_done;
          status    <= lrb_pkg::ST_OK;
          length    <= (st.at_end || st.cnt_done) ? k_n : '0;
        end
        lrb_pkg::CMD_LINE_STEP: begin
          if (st.is_cr) begin
            out_byte  <= lrb_pkg::NUL_BYTE;
            last      <= 1'b1;
            status    <= lrb_pkg::ST_OK;
            length    <= k;
          end else if (!is_lf && k < lrb_pkg::LINE_CAP) begin
            out_byte  <= mem_q;
            last      <= 1'b0;
            status    <= lrb_pkg::ST_OK;
            length    <= '0;
          end
        end
        lrb_pkg::CMD_TERM: begin
          out_byte  <= lrb_pkg::NUL_BYTE;
          last      <= 1'b1;
          status    <= cmd.status;
          length    <= k;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/core/line_aware_receive_ring_buffer_core.sv
// Line-aware receive ring buffer, top level: sequencer plus ring datapath.
// Depends on lrb_pkg, lrb_req_if/lrb_res_if, lrb_ctrl and lrb_dp.
//
// Usage:
//   req is a valid/ready request channel: push a received byte, read up to
//   read_count bytes, or read one CR-terminated line, on one of the channels.
//   res is a valid/ready result channel; every request but an unknown code
//   gives one or more results, and the final one carries last, status, length.
//   A push transfer gives its result in the next cycle, and pushes can follow
//   back to back at one per cycle while res keeps up.
//   A read first fetches the byte at the read pointer; a count read then gives
//   one result per cycle while res keeps up; a line read walks one byte per step,
//   skipped LF bytes included, then one more step for a flushed-line terminator.
//   The request channel is held off until a read has finished walking; the
//   single-port ring read (one byte per cycle while res keeps up) sets the read rate.
//   Each channel ring holds DEPTH-1 bytes; a push into a full ring is dropped
//   with overflow status.
//   Reset (rst, synchronous) empties all rings and clears the line counts;
//   no clearing pass is needed. When res stalls, the result register holds,
//   the read walker stops and no new request is taken.
module line_aware_receive_ring_buffer_core (
  input logic         clk,
  input logic         rst,
  lrb_req_if.sink     req,
  lrb_res_if.source   res
);

  lrb_pkg::cmd_t  cmd;
  lrb_pkg::stat_t st;

  // Decode requests and pace the read walk
  lrb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_type  (req.req_type),
    .st        (st),
    .cmd       (cmd),
    .req_ready (req.ready)
  );

  // Ring storage, pointers, line counts and result register
  lrb_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .channel    (req.channel),
    .rx_byte    (req.rx_byte),
    .read_count (req.read_count),
    .res_ready  (res.ready),
    .res_valid  (res.valid),
    .out_byte   (res.out_byte),
    .last       (res.last),
    .status     (res.status),
    .length     (res.length)
  );

`ifndef SYNTH
  // Never take a request while an untaken result would be overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> (!res.valid || res.ready))
    else $error("request taken while result register busy");

  // A push transfer always produces its result on the next cycle
  a_push_result: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.req_type == lrb_pkg::REQ_PUSH) |=> (res.valid && res.last))
    else $error("push transfer without result");

  // Intermediate results carry ok status and zero length
  a_mid_fields: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.last) |-> (res.status == lrb_pkg::ST_OK && res.length == '0))
    else $error("non-final result with status or length");
`endif

endmodule
